/* hdl/ecpa_pkg.sv */
// ----------------------------------------------------------------------------
// ecpa_pkg: shared types and microcode for the affine point adder
// Holds the micro-instruction format, the command and status bundles between
// the controller and the datapath, storage slot names and the microprogram.
// ----------------------------------------------------------------------------
package ecpa_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_CURVE_A = 2'd1;
  localparam logic [1:0] CFG_CURVE_B = 2'd2;

  // Working storage slots.
  localparam int unsigned SLOT_AW = 4;
  localparam int unsigned SLOT_N  = 16;
  localparam logic [SLOT_AW-1:0] SL_PX  = 4'd0;
  localparam logic [SLOT_AW-1:0] SL_PY  = 4'd1;
  localparam logic [SLOT_AW-1:0] SL_QX  = 4'd2;
  localparam logic [SLOT_AW-1:0] SL_QY  = 4'd3;
  localparam logic [SLOT_AW-1:0] SL_A   = 4'd4;
  localparam logic [SLOT_AW-1:0] SL_B   = 4'd5;
  localparam logic [SLOT_AW-1:0] SL_T1  = 4'd6;
  localparam logic [SLOT_AW-1:0] SL_T2  = 4'd7;
  localparam logic [SLOT_AW-1:0] SL_T3  = 4'd8;
  localparam logic [SLOT_AW-1:0] SL_NUM = 4'd9;
  localparam logic [SLOT_AW-1:0] SL_DEN = 4'd10;
  localparam logic [SLOT_AW-1:0] SL_LAM = 4'd11;
  localparam logic [SLOT_AW-1:0] SL_RX  = 4'd12;
  localparam logic [SLOT_AW-1:0] SL_RY  = 4'd13;

  // Small constants of the formulas, used as immediate operands.
  localparam logic [4:0] C_ZERO  = 5'd0;
  localparam logic [4:0] C_THREE = 5'd3;
  localparam logic [4:0] C_FOUR  = 5'd4;
  localparam logic [4:0] C_SIXTN = 5'd16;
  localparam logic [4:0] C_TWSEV = 5'd27;

  // Microprogram section entry points.
  localparam int unsigned PC_W = 6;
  localparam logic [PC_W-1:0] PC_COMMON = 6'd0;
  localparam logic [PC_W-1:0] PC_COPYQ  = 6'd25;
  localparam logic [PC_W-1:0] PC_COPYP  = 6'd27;
  localparam logic [PC_W-1:0] PC_DBL    = 6'd29;
  localparam logic [PC_W-1:0] PC_CHORD  = 6'd33;
  localparam logic [PC_W-1:0] PC_INV    = 6'd35;
  localparam logic [PC_W-1:0] PC_FIN    = 6'd36;

  typedef enum logic [2:0] {
    OP_RED, OP_ADD, OP_SUB, OP_MUL, OP_INV, OP_CMP
  } op_e;

  typedef enum logic [2:0] {
    RAW_PX, RAW_PY, RAW_QX, RAW_QY, RAW_A, RAW_B
  } raw_e;

  typedef enum logic [2:0] {
    FLG_NONE, FLG_PON, FLG_SING, FLG_X, FLG_Y, FLG_NEG
  } flag_e;

  typedef struct packed {
    op_e                op;
    raw_e               src;
    logic [SLOT_AW-1:0] ra;
    logic [SLOT_AW-1:0] rb;
    logic               bimm;
    logic [4:0]         imm;
    logic [SLOT_AW-1:0] dst;
    flag_e              flg;
    logic               last;
  } instr_t;

  typedef struct packed {
    logic   load;
    logic   start;
    instr_t ins;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic pinf;
    logic qinf;
    logic pon;
    logic sing;
    logic x_eq;
    logic y_eq;
    logic neg_eq;
    logic inv_ok;
  } sts_t;

  function automatic instr_t ui(op_e op, raw_e src, logic [SLOT_AW-1:0] ra,
                                logic [SLOT_AW-1:0] rb, logic bimm, logic [4:0] imm,
                                logic [SLOT_AW-1:0] dst, flag_e flg, logic last);
    instr_t r;
    r.op   = op;
    r.src  = src;
    r.ra   = ra;
    r.rb   = rb;
    r.bimm = bimm;
    r.imm  = imm;
    r.dst  = dst;
    r.flg  = flg;
    r.last = last;
    return r;
  endfunction

  function automatic instr_t ucode(logic [PC_W-1:0] pc);
    instr_t r;
    case (pc)
      // Reduce inputs and coefficients.
      6'd0:  r = ui(OP_RED, RAW_PX, SL_PX, SL_PX, 1'b0, C_ZERO, SL_PX, FLG_NONE, 1'b0);
      6'd1:  r = ui(OP_RED, RAW_PY, SL_PX, SL_PX, 1'b0, C_ZERO, SL_PY, FLG_NONE, 1'b0);
      6'd2:  r = ui(OP_RED, RAW_QX, SL_PX, SL_PX, 1'b0, C_ZERO, SL_QX, FLG_NONE, 1'b0);
      6'd3:  r = ui(OP_RED, RAW_QY, SL_PX, SL_PX, 1'b0, C_ZERO, SL_QY, FLG_NONE, 1'b0);
      6'd4:  r = ui(OP_RED, RAW_A,  SL_PX, SL_PX, 1'b0, C_ZERO, SL_A,  FLG_NONE, 1'b0);
      6'd5:  r = ui(OP_RED, RAW_B,  SL_PX, SL_PX, 1'b0, C_ZERO, SL_B,  FLG_NONE, 1'b0);
      // Curve test on P.
      6'd6:  r = ui(OP_MUL, RAW_PX, SL_PY, SL_PY, 1'b0, C_ZERO, SL_T1, FLG_NONE, 1'b0);
      6'd7:  r = ui(OP_MUL, RAW_PX, SL_PX, SL_PX, 1'b0, C_ZERO, SL_T2, FLG_NONE, 1'b0);
      6'd8:  r = ui(OP_MUL, RAW_PX, SL_T2, SL_PX, 1'b0, C_ZERO, SL_T2, FLG_NONE, 1'b0);
      6'd9:  r = ui(OP_MUL, RAW_PX, SL_A,  SL_PX, 1'b0, C_ZERO, SL_T3, FLG_NONE, 1'b0);
      6'd10: r = ui(OP_ADD, RAW_PX, SL_T2, SL_T3, 1'b0, C_ZERO, SL_T2, FLG_NONE, 1'b0);
      6'd11: r = ui(OP_ADD, RAW_PX, SL_T2, SL_B,  1'b0, C_ZERO, SL_T2, FLG_NONE, 1'b0);
      6'd12: r = ui(OP_CMP, RAW_PX, SL_T1, SL_T2, 1'b0, C_ZERO, SL_T1, FLG_PON,  1'b0);
      // Discriminant; the sign does not change whether it is zero.
      6'd13: r = ui(OP_MUL, RAW_PX, SL_A,  SL_A,  1'b0, C_ZERO,  SL_T1, FLG_NONE, 1'b0);
      6'd14: r = ui(OP_MUL, RAW_PX, SL_T1, SL_A,  1'b0, C_ZERO,  SL_T1, FLG_NONE, 1'b0);
      6'd15: r = ui(OP_MUL, RAW_PX, SL_T1, SL_A,  1'b1, C_FOUR,  SL_T1, FLG_NONE, 1'b0);
      6'd16: r = ui(OP_MUL, RAW_PX, SL_B,  SL_B,  1'b0, C_ZERO,  SL_T2, FLG_NONE, 1'b0);
      6'd17: r = ui(OP_MUL, RAW_PX, SL_T2, SL_B,  1'b1, C_TWSEV, SL_T2, FLG_NONE, 1'b0);
      6'd18: r = ui(OP_ADD, RAW_PX, SL_T1, SL_T2, 1'b0, C_ZERO,  SL_T1, FLG_NONE, 1'b0);
      6'd19: r = ui(OP_MUL, RAW_PX, SL_T1, SL_A,  1'b1, C_SIXTN, SL_T1, FLG_NONE, 1'b0);
      6'd20: r = ui(OP_CMP, RAW_PX, SL_T1, SL_A,  1'b1, C_ZERO,  SL_T1, FLG_SING, 1'b0);
      // Case tests: Q is -P when py + qy is zero.
      6'd21: r = ui(OP_ADD, RAW_PX, SL_PY, SL_QY, 1'b0, C_ZERO, SL_T1, FLG_NONE, 1'b0);
      6'd22: r = ui(OP_CMP, RAW_PX, SL_T1, SL_A,  1'b1, C_ZERO, SL_T1, FLG_NEG,  1'b0);
      6'd23: r = ui(OP_CMP, RAW_PX, SL_PX, SL_QX, 1'b0, C_ZERO, SL_T1, FLG_X,    1'b0);
      6'd24: r = ui(OP_CMP, RAW_PX, SL_PY, SL_QY, 1'b0, C_ZERO, SL_T1, FLG_Y,    1'b1);
      // Pass one point through.
      6'd25: r = ui(OP_ADD, RAW_PX, SL_QX, SL_A, 1'b1, C_ZERO, SL_RX, FLG_NONE, 1'b0);
      6'd26: r = ui(OP_ADD, RAW_PX, SL_QY, SL_A, 1'b1, C_ZERO, SL_RY, FLG_NONE, 1'b1);
      6'd27: r = ui(OP_ADD, RAW_PX, SL_PX, SL_A, 1'b1, C_ZERO, SL_RX, FLG_NONE, 1'b0);
      6'd28: r = ui(OP_ADD, RAW_PX, SL_PY, SL_A, 1'b1, C_ZERO, SL_RY, FLG_NONE, 1'b1);
      // Tangent numerator and denominator.
      6'd29: r = ui(OP_MUL, RAW_PX, SL_PX, SL_PX, 1'b0, C_ZERO,  SL_T1,  FLG_NONE, 1'b0);
      6'd30: r = ui(OP_MUL, RAW_PX, SL_T1, SL_A,  1'b1, C_THREE, SL_T1,  FLG_NONE, 1'b0);
      6'd31: r = ui(OP_ADD, RAW_PX, SL_T1, SL_A,  1'b0, C_ZERO,  SL_NUM, FLG_NONE, 1'b0);
      6'd32: r = ui(OP_ADD, RAW_PX, SL_PY, SL_PY, 1'b0, C_ZERO,  SL_DEN, FLG_NONE, 1'b1);
      // Chord numerator and denominator.
      6'd33: r = ui(OP_SUB, RAW_PX, SL_QY, SL_PY, 1'b0, C_ZERO, SL_NUM, FLG_NONE, 1'b0);
      6'd34: r = ui(OP_SUB, RAW_PX, SL_QX, SL_PX, 1'b0, C_ZERO, SL_DEN, FLG_NONE, 1'b1);
      // Inverse of the denominator.
      6'd35: r = ui(OP_INV, RAW_PX, SL_DEN, SL_A, 1'b0, C_ZERO, SL_T1, FLG_NONE, 1'b1);
      // Slope and the new point.
      6'd36: r = ui(OP_MUL, RAW_PX, SL_NUM, SL_T1,  1'b0, C_ZERO, SL_LAM, FLG_NONE, 1'b0);
      6'd37: r = ui(OP_MUL, RAW_PX, SL_LAM, SL_LAM, 1'b0, C_ZERO, SL_T2,  FLG_NONE, 1'b0);
      6'd38: r = ui(OP_SUB, RAW_PX, SL_T2,  SL_PX,  1'b0, C_ZERO, SL_T2,  FLG_NONE, 1'b0);
      6'd39: r = ui(OP_SUB, RAW_PX, SL_T2,  SL_QX,  1'b0, C_ZERO, SL_T2,  FLG_NONE, 1'b0);
      6'd40: r = ui(OP_ADD, RAW_PX, SL_T2,  SL_A,   1'b1, C_ZERO, SL_RX,  FLG_NONE, 1'b0);
      6'd41: r = ui(OP_SUB, RAW_PX, SL_PX,  SL_T2,  1'b0, C_ZERO, SL_T3,  FLG_NONE, 1'b0);
      6'd42: r = ui(OP_MUL, RAW_PX, SL_LAM, SL_T3,  1'b0, C_ZERO, SL_T3,  FLG_NONE, 1'b0);
      6'd43: r = ui(OP_SUB, RAW_PX, SL_T3,  SL_PY,  1'b0, C_ZERO, SL_RY,  FLG_NONE, 1'b1);
      default: r = ui(OP_CMP, RAW_PX, SL_T1, SL_T1, 1'b0, C_ZERO, SL_T1, FLG_NONE, 1'b1);
    endcase
    return r;
  endfunction

endpackage

/* hdl/ecpa_ram.sv */
// ----------------------------------------------------------------------------
// ecpa_ram: generic storage array
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ecpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rda_q;
  logic [WIDTH-1:0] rdb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rda_q <= mem_q[raddr_a_i];
    rdb_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rda_q;
  assign rdata_b_o = rdb_q;

endmodule

/* hdl/ecpa_datapath.sv */
// ----------------------------------------------------------------------------
// ecpa_datapath: modular arithmetic unit with working storage
// Executes one micro-instruction at a time: reduction and multiplication one
// bit per cycle, add, subtract and compare without iteration, and inversion
// by the extended Euclidean algorithm with a bit-serial divider.
// ----------------------------------------------------------------------------
module ecpa_datapath #(
  parameter int unsigned W = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ecpa_pkg::cmd_t  cmd_i,
  output ecpa_pkg::sts_t  sts_o,
  input  logic [W-1:0]    mod_i,
  input  logic [W-1:0]    cfg_a_i,
  input  logic [W-1:0]    cfg_b_i,
  input  logic [W-1:0]    in_px_i,
  input  logic [W-1:0]    in_py_i,
  input  logic [W-1:0]    in_qx_i,
  input  logic [W-1:0]    in_qy_i,
  input  logic            in_pinf_i,
  input  logic            in_qinf_i,
  output logic [W-1:0]    rx_o,
  output logic [W-1:0]    ry_o
);

  localparam int unsigned CW = $clog2(W);

  function automatic logic [W-1:0] addm(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] m);
    logic [W-1:0] d;
    d = x - y;
    if (x < y) begin
      d = d + m;
    end
    return d;
  endfunction

  logic [W-1:0] m;
  logic [W-1:0] rd_a, rd_b, raw_sel, opa, opb;
  logic [W-1:0] res;
  logic         done, we;

  logic [W-1:0] px_q, py_q, qx_q, qy_q;
  logic         pinf_q, qinf_q;
  logic [W-1:0] rx_q, rx_d, ry_q, ry_d;

  logic                      busy_q, busy_d, div_q, div_d;
  ecpa_pkg::op_e             op_q, op_d;
  ecpa_pkg::flag_e           flg_q, flg_d;
  logic [ecpa_pkg::SLOT_AW-1:0] dst_q, dst_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [W-1:0]              a_q, a_d, b_q, b_d, acc_q, acc_d, qt_q, qt_d;
  logic [W-1:0]              r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic pon_q, pon_d, sing_q, sing_d, xeq_q, xeq_d, yeq_q, yeq_d;
  logic neg_q, neg_d, inv_q, inv_d;

  assign m = (mod_i == '0) ? W'(1) : mod_i;

  ecpa_ram #(
    .WIDTH (W),
    .DEPTH (ecpa_pkg::SLOT_N)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (dst_q),
    .wdata_i   (res),
    .raddr_a_i (cmd_i.ins.ra),
    .raddr_b_i (cmd_i.ins.rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    case (cmd_i.ins.src)
      ecpa_pkg::RAW_PX: raw_sel = px_q;
      ecpa_pkg::RAW_PY: raw_sel = py_q;
      ecpa_pkg::RAW_QX: raw_sel = qx_q;
      ecpa_pkg::RAW_QY: raw_sel = qy_q;
      ecpa_pkg::RAW_A:  raw_sel = cfg_a_i;
      ecpa_pkg::RAW_B:  raw_sel = cfg_b_i;
      default:          raw_sel = px_q;
    endcase
  end

  assign opa = (cmd_i.ins.op == ecpa_pkg::OP_RED) ? raw_sel : rd_a;
  assign opb = cmd_i.ins.bimm ? W'(cmd_i.ins.imm) : rd_b;

  always_comb begin
    logic [W:0]   sh;
    logic [W-1:0] t;
    logic         qb;
    sh     = '0;
    t      = '0;
    qb     = 1'b0;
    busy_d = busy_q;
    div_d  = div_q;
    op_d   = op_q;
    flg_d  = flg_q;
    dst_d  = dst_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    qt_d   = qt_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    t0_d   = t0_q;
    t1_d   = t1_q;
    pon_d  = pon_q;
    sing_d = sing_q;
    xeq_d  = xeq_q;
    yeq_d  = yeq_q;
    neg_d  = neg_q;
    inv_d  = inv_q;
    done   = 1'b0;
    res    = '0;

    if (busy_q) begin
      case (op_q)
        ecpa_pkg::OP_ADD: begin
          res  = addm(a_q, b_q, m);
          done = 1'b1;
        end
        ecpa_pkg::OP_SUB: begin
          res  = subm(a_q, b_q, m);
          done = 1'b1;
        end
        ecpa_pkg::OP_CMP: begin
          done = 1'b1;
        end
        ecpa_pkg::OP_RED: begin
          sh = {acc_q, b_q[W-1]};
          if (sh >= {1'b0, m}) begin
            sh = sh - {1'b0, m};
          end
          acc_d = sh[W-1:0];
          b_d   = b_q << 1;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            done = 1'b1;
            res  = sh[W-1:0];
          end
        end
        ecpa_pkg::OP_MUL: begin
          // Multiplier bits enter from the top: double, then add.
          t = addm(acc_q, acc_q, m);
          if (b_q[W-1]) begin
            t = addm(t, a_q, m);
          end
          acc_d = t;
          b_d   = b_q << 1;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == '0) begin
            done = 1'b1;
            res  = t;
          end
        end
        ecpa_pkg::OP_INV: begin
          if (!div_q) begin
            if (r1_q == '0) begin
              done  = 1'b1;
              res   = t0_q;
              inv_d = (r0_q == W'(1));
            end else begin
              div_d = 1'b1;
              acc_d = '0;
              b_d   = r0_q;
              qt_d  = '0;
              cnt_d = CW'(W - 1);
            end
          end else begin
            // Long division of r0 by r1; the quotient times t1 builds up
            // alongside, one quotient bit per cycle.
            sh = {acc_q, b_q[W-1]};
            qb = (sh >= {1'b0, r1_q});
            if (qb) begin
              sh = sh - {1'b0, r1_q};
            end
            acc_d = sh[W-1:0];
            t = addm(qt_q, qt_q, m);
            if (qb) begin
              t = addm(t, t1_q, m);
            end
            qt_d  = t;
            b_d   = b_q << 1;
            cnt_d = cnt_q - 1'b1;
            if (cnt_q == '0) begin
              r0_d  = r1_q;
              r1_d  = sh[W-1:0];
              t0_d  = t1_q;
              t1_d  = subm(t0_q, t, m);
              div_d = 1'b0;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase

      if (done) begin
        busy_d = 1'b0;
        if (op_q == ecpa_pkg::OP_CMP) begin
          case (flg_q)
            ecpa_pkg::FLG_PON:  pon_d  = (a_q == b_q);
            ecpa_pkg::FLG_SING: sing_d = (a_q == b_q);
            ecpa_pkg::FLG_X:    xeq_d  = (a_q == b_q);
            ecpa_pkg::FLG_Y:    yeq_d  = (a_q == b_q);
            ecpa_pkg::FLG_NEG:  neg_d  = (a_q == b_q);
            default: ;
          endcase
        end
      end
    end

    if (cmd_i.start) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      op_d   = cmd_i.ins.op;
      flg_d  = cmd_i.ins.flg;
      dst_d  = cmd_i.ins.dst;
      cnt_d  = CW'(W - 1);
      a_d    = opa;
      b_d    = (cmd_i.ins.op == ecpa_pkg::OP_RED) ? opa : opb;
      acc_d  = '0;
      r0_d   = m;
      r1_d   = opa;
      t0_d   = '0;
      t1_d   = (m == W'(1)) ? '0 : W'(1);
    end
  end

  assign we = done && (op_q != ecpa_pkg::OP_CMP);

  always_comb begin
    rx_d = rx_q;
    ry_d = ry_q;
    if (we && dst_q == ecpa_pkg::SL_RX) begin
      rx_d = res;
    end
    if (we && dst_q == ecpa_pkg::SL_RY) begin
      ry_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      op_q   <= ecpa_pkg::OP_CMP;
      flg_q  <= ecpa_pkg::FLG_NONE;
      pon_q  <= 1'b0;
      sing_q <= 1'b0;
      xeq_q  <= 1'b0;
      yeq_q  <= 1'b0;
      neg_q  <= 1'b0;
      inv_q  <= 1'b0;
      pinf_q <= 1'b0;
      qinf_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      op_q   <= op_d;
      flg_q  <= flg_d;
      pon_q  <= pon_d;
      sing_q <= sing_d;
      xeq_q  <= xeq_d;
      yeq_q  <= yeq_d;
      neg_q  <= neg_d;
      inv_q  <= inv_d;
      if (cmd_i.load) begin
        pinf_q <= in_pinf_i;
        qinf_q <= in_qinf_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
    cnt_q <= cnt_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    qt_q  <= qt_d;
    r0_q  <= r0_d;
    r1_q  <= r1_d;
    t0_q  <= t0_d;
    t1_q  <= t1_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    if (cmd_i.load) begin
      px_q <= in_px_i;
      py_q <= in_py_i;
      qx_q <= in_qx_i;
      qy_q <= in_qy_i;
    end
  end

  assign sts_o.done   = done;
  assign sts_o.pinf   = pinf_q;
  assign sts_o.qinf   = qinf_q;
  assign sts_o.pon    = pon_q;
  assign sts_o.sing   = sing_q;
  assign sts_o.x_eq   = xeq_q;
  assign sts_o.y_eq   = yeq_q;
  assign sts_o.neg_eq = neg_q;
  assign sts_o.inv_ok = inv_q;
  assign rx_o = rx_q;
  assign ry_o = ry_q;

endmodule

/* hdl/ecpa_ctrl.sv */
// ----------------------------------------------------------------------------
// ecpa_ctrl: sequencer for the affine point adder
// Steps through the microprogram, picks the addition case from the datapath
// flags and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module ecpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  output logic           out_load_o,
  output logic           out_inf_o,
  output ecpa_pkg::cmd_t cmd_o,
  input  ecpa_pkg::sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_GO   = 6'b000100,
    ST_WT   = 6'b001000,
    ST_BR   = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    SEC_COMMON, SEC_COPY, SEC_SLOPE, SEC_INV, SEC_FIN
  } sec_e;

  state_e                     state_q, state_d;
  sec_e                       sec_q, sec_d;
  logic [ecpa_pkg::PC_W-1:0]  pc_q, pc_d;
  logic                       inf_q, inf_d;
  logic                       accept;
  ecpa_pkg::instr_t           ins;

  assign ins    = ecpa_pkg::ucode(pc_q);
  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d    = state_q;
    sec_d      = sec_q;
    pc_d       = pc_q;
    inf_d      = inf_q;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RD;
          sec_d   = SEC_COMMON;
          pc_d    = ecpa_pkg::PC_COMMON;
          inf_d   = 1'b0;
        end
      end
      ST_RD: state_d = ST_GO;
      ST_GO: state_d = ST_WT;
      ST_WT: begin
        if (sts_i.done) begin
          if (ins.last) begin
            state_d = ST_BR;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_BR: begin
        state_d = ST_RD;
        case (sec_q)
          SEC_COMMON: begin
            if (sts_i.pinf && sts_i.qinf) begin
              inf_d   = 1'b1;
              state_d = ST_OUT;
            end else if (sts_i.pinf) begin
              sec_d = SEC_COPY;
              pc_d  = ecpa_pkg::PC_COPYQ;
            end else if (sts_i.qinf) begin
              sec_d = SEC_COPY;
              pc_d  = ecpa_pkg::PC_COPYP;
            end else if (sts_i.x_eq && sts_i.neg_eq) begin
              inf_d   = 1'b1;
              state_d = ST_OUT;
            end else if (sts_i.x_eq && sts_i.y_eq) begin
              sec_d = SEC_SLOPE;
              pc_d  = ecpa_pkg::PC_DBL;
            end else begin
              sec_d = SEC_SLOPE;
              pc_d  = ecpa_pkg::PC_CHORD;
            end
          end
          SEC_SLOPE: begin
            sec_d = SEC_INV;
            pc_d  = ecpa_pkg::PC_INV;
          end
          SEC_INV: begin
            if (sts_i.inv_ok) begin
              sec_d = SEC_FIN;
              pc_d  = ecpa_pkg::PC_FIN;
            end else begin
              inf_d   = 1'b1;
              state_d = ST_OUT;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= SEC_COMMON;
      pc_q    <= ecpa_pkg::PC_COMMON;
      inf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      pc_q    <= pc_d;
      inf_q   <= inf_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_inf_o   = inf_q;
  assign cmd_o.load  = accept;
  assign cmd_o.start = (state_q == ST_GO);
  assign cmd_o.ins   = ins;

endmodule

/* hdl/ec_affine_point_add_unit.sv */
// ----------------------------------------------------------------------------
// ec_affine_point_add_unit: affine point addition on y^2 = x^3 + ax + b
// Adds two points modulo a configurable modulus, and reports whether P lies
// on the curve and whether the configured curve is singular.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tdata {q_y, q_x, p_y, p_x}, tuser {q_inf, p_inf}
//  m_axis    out        tdata {r_y, r_x}, tuser {curve_singular, p_on_curve, r_inf}
//  cfg       in         cfg_index_i: 0 modulus, 1 curve_a, 2 curve_b
//
// One point pair is worked on at a time. Each micro-instruction passes through
// a read state and an issue state before it executes: a reduction or a
// multiplication bit-serially, add, subtract or compare without iteration.
// The inversion runs Euclid steps, each a bit-serial division, at most about
// 1.44 * FIELD_BITS of them. Doubling and chord addition differ only in the
// slope section; the special cases finish without an inversion. A finished
// result waits in the output register while the next pair is taken. Reset
// loads the default curve; configuration is always ready.
// ----------------------------------------------------------------------------
module ec_affine_point_add_unit #(
  parameter int unsigned FIELD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [127:0]          s_axis_tdata,   // p_x, p_y, q_x, q_y
  input  logic [1:0]            s_axis_tuser,   // p_inf, q_inf
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,   // r_x, r_y
  output logic [2:0]            m_axis_tuser,   // r_inf, p_on_curve, curve_singular
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [FIELD_BITS-1:0] cfg_data_i
);

  localparam int unsigned W = FIELD_BITS;

  logic [W-1:0]   mod_q, a_q, b_q;
  logic [W-1:0]   rx, ry;
  logic           out_free, out_load, out_inf;
  logic           mv_q;
  logic [63:0]    md_q;
  logic [2:0]     mu_q;
  ecpa_pkg::cmd_t cmd;
  ecpa_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= W'(33'd4294967291);
      a_q   <= '0;
      b_q   <= W'(4'd7);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ecpa_pkg::CFG_MODULUS: mod_q <= cfg_data_i;
        ecpa_pkg::CFG_CURVE_A: a_q   <= cfg_data_i;
        ecpa_pkg::CFG_CURVE_B: b_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ecpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .out_inf_o  (out_inf),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ecpa_datapath #(
    .W (W)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .mod_i     (mod_q),
    .cfg_a_i   (a_q),
    .cfg_b_i   (b_q),
    .in_px_i   (W'(s_axis_tdata[31:0])),
    .in_py_i   (W'(s_axis_tdata[63:32])),
    .in_qx_i   (W'(s_axis_tdata[95:64])),
    .in_qy_i   (W'(s_axis_tdata[127:96])),
    .in_pinf_i (s_axis_tuser[0]),
    .in_qinf_i (s_axis_tuser[1]),
    .rx_o      (rx),
    .ry_o      (ry)
  );

  assign out_free = !mv_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (out_load) begin
      mv_q <= 1'b1;
    end else if (m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      md_q <= out_inf ? 64'd0 : {32'(ry), 32'(rx)};
      mu_q <= {sts.sing, sts.pon, out_inf};
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;
  assign m_axis_tuser  = mu_q;

endmodule

/* verif/ec_affine_point_add_unit_tb.sv */
// ----------------------------------------------------------------------------
// ec_affine_point_add_unit_tb: self-checking bench for the affine point adder
// Walks a short table of directed point pairs, then random pairs under a
// series of curve settings. Every result beat is compared with its expected
// sum, from the table for typed rows and else computed in this bench from
// the two points, including the curve membership and singularity flags.
// ----------------------------------------------------------------------------
module ec_affine_point_add_unit_tb;

  localparam int unsigned WDOG_LIMIT = 40000;
  localparam int unsigned LONG_HOLD  = 3000;
  localparam int unsigned N_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS = 62;

  typedef struct {
    logic [31:0] px, py;
    logic        pinf;
    logic [31:0] qx, qy;
    logic        qinf;
  } pair_t;

  typedef struct packed {
    logic [31:0] rx, ry;
    logic        rinf, pon, sing;
  } sum_t;

  typedef struct {
    pair_t pr;
    logic  typed;
    sum_t  sum;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // p_x, p_y, q_x, q_y
  logic [1:0] s_axis_tuser = '0;    // p_inf, q_inf
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // r_x, r_y
  logic [2:0] m_axis_tuser;         // r_inf, p_on_curve, curve_singular
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = ecpa_pkg::CFG_MODULUS;
  logic [31:0] cfg_data_i = '0;

  // Shadow copy of the curve registers.
  logic [31:0] modulus_q = 32'd4294967291;
  logic [31:0] coef_a_q = 32'd0;
  logic [31:0] coef_b_q = 32'd7;

  sum_t expected_sums[$];
  int unsigned mismatches = 0;
  int unsigned sums_seen = 0;
  int unsigned pairs_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  ec_affine_point_add_unit #(.FIELD_BITS(32)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // ---------------- field arithmetic ----------------
  function automatic longint unsigned field_mod();
    return (modulus_q == 0) ? 64'd1 : {32'd0, modulus_q};
  endfunction

  function automatic longint unsigned fadd(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    return (x + y) % m;
  endfunction

  function automatic longint unsigned fsub(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    return (x + m - y) % m;
  endfunction

  function automatic longint unsigned fmul(longint unsigned x, longint unsigned y,
                                           longint unsigned m);
    return (x * y) % m;
  endfunction

  // Extended Euclid; fails when gcd(x, m) is not one.
  function automatic bit finv(longint unsigned x, longint unsigned m,
                              output longint unsigned res);
    longint unsigned r0, r1, t0, t1, q, nr, nt;
    r0 = m; r1 = x % m; t0 = 0; t1 = 1 % m;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      nt = fsub(t0, fmul(q % m, t1, m), m);
      r0 = r1; r1 = nr;
      t0 = t1; t1 = nt;
    end
    res = t0;
    return r0 == 1;
  endfunction

  function automatic sum_t point_sum(pair_t p);
    longint unsigned m, a, b, px, py, qx, qy, num, den, inv, lam, t, lhs, rhs, disc;
    sum_t s;
    m = field_mod();
    a = coef_a_q % m; b = coef_b_q % m;
    px = p.px % m; py = p.py % m; qx = p.qx % m; qy = p.qy % m;
    s = '{rx: 0, ry: 0, rinf: 0, pon: 0, sing: 0};
    lhs = fmul(py, py, m);
    rhs = fadd(fadd(fmul(fmul(px, px, m), px, m), fmul(a, px, m), m), b, m);
    s.pon = (lhs == rhs);
    disc = fadd(fmul(4 % m, fmul(fmul(a, a, m), a, m), m),
                fmul(27 % m, fmul(b, b, m), m), m);
    disc = fsub(0, fmul(16 % m, disc, m), m);
    s.sing = (disc == 0);
    if (p.pinf && p.qinf) begin
      s.rinf = 1'b1;
    end else if (p.pinf) begin
      s.rx = 32'(qx); s.ry = 32'(qy);
    end else if (p.qinf) begin
      s.rx = 32'(px); s.ry = 32'(py);
    end else if (px == qx && py == fsub(0, qy, m)) begin
      s.rinf = 1'b1;
    end else begin
      if (px == qx && py == qy) begin
        num = fadd(fmul(3 % m, fmul(px, px, m), m), a, m);
        den = fadd(py, py, m);
      end else begin
        num = fsub(qy, py, m);
        den = fsub(qx, px, m);
      end
      if (!finv(den, m, inv)) begin
        s.rinf = 1'b1;
      end else begin
        lam = fmul(num, inv, m);
        t = fsub(fsub(fmul(lam, lam, m), px, m), qx, m);
        s.ry = 32'(fsub(fmul(lam, fsub(px, t, m), m), py, m));
        s.rx = 32'(t);
      end
    end
    if (s.rinf) begin
      s.rx = 0; s.ry = 0;
    end
    return s;
  endfunction

  // ---------------- stimulus helpers ----------------
  // Random point on the curve when the field is small enough to search.
  function automatic void curve_point(output logic [31:0] x, output logic [31:0] y);
    longint unsigned m, a, b, cx, rhs;
    m = field_mod();
    a = coef_a_q % m; b = coef_b_q % m;
    x = $urandom; y = $urandom;
    if (m > 1200) return;
    for (int tries = 0; tries < 30; tries++) begin
      cx = $urandom_range(0, int'(m - 1));
      rhs = fadd(fadd(fmul(fmul(cx, cx, m), cx, m), fmul(a, cx, m), m), b, m);
      for (longint unsigned cy = 0; cy < m; cy++) begin
        if (fmul(cy, cy, m) == rhs) begin
          x = 32'(cx);
          y = ($urandom_range(0, 1) == 1) ? 32'(fsub(0, cy, m)) : 32'(cy);
          return;
        end
      end
    end
  endfunction

  // Now and then adds a random multiple of the modulus so that reduction is exercised.
  function automatic logic [31:0] unreduce(logic [31:0] v);
    longint unsigned m, room;
    m = field_mod();
    if ($urandom_range(0, 3) != 0) return v;
    room = (64'hFFFF_FFFF - v) / m;
    if (room > 64'hFFFF_FFFF) room = 64'hFFFF_FFFF;
    return 32'(v + m * $urandom_range(0, int'(room[31:0])));
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    p.pinf = 1'b0; p.qinf = 1'b0;
    curve_point(p.px, p.py);
    curve_point(p.qx, p.qy);
    if (kind < 10) begin
      p = '{px: $urandom, py: $urandom, pinf: $urandom_range(0, 1),
            qx: $urandom, qy: $urandom, qinf: $urandom_range(0, 1)};
    end else if (kind < 20) begin
      if ($urandom_range(0, 1) == 1) p.pinf = 1'b1;
      else p.qinf = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        p.pinf = 1'b1; p.qinf = 1'b1;
      end
    end else if (kind < 42) begin
      p.qx = p.px; p.qy = p.py;
    end else if (kind < 56) begin
      p.qx = p.px;
      p.qy = 32'(fsub(0, p.py % field_mod(), field_mod()));
    end else if (kind < 62) begin
      // Same x, unrelated y.
      p.qx = p.px;
    end
    p.px = unreduce(p.px); p.py = unreduce(p.py);
    p.qx = unreduce(p.qx); p.qy = unreduce(p.qy);
    return p;
  endfunction

  // ---------------- sender ----------------
  task automatic send_pair(pair_t p, logic typed, sum_t sum);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {p.qy, p.qx, p.py, p.px};
    s_axis_tuser <= {p.qinf, p.pinf};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_sums.push_back(typed ? sum : point_sum(p));
    pairs_sent++;
  endtask

  // Writes all three curve registers once the adder has drained.
  task automatic set_curve(logic [31:0] m, logic [31:0] a, logic [31:0] b);
    logic [31:0] vals[3];
    logic [1:0] idx[3];
    s_axis_tvalid <= 1'b0;
    wait (expected_sums.size() == 0);
    repeat (20) @(posedge clk_i);
    vals = '{m, a, b};
    idx = '{ecpa_pkg::CFG_MODULUS, ecpa_pkg::CFG_CURVE_A, ecpa_pkg::CFG_CURVE_B};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    modulus_q = m; coef_a_q = a; coef_b_q = b;
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    sum_t got, want;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = idle_on ? $urandom_range(0, 13) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = '{rx: m_axis_tdata[31:0], ry: m_axis_tdata[63:32], rinf: m_axis_tuser[0],
              pon: m_axis_tuser[1], sing: m_axis_tuser[2]};
      sums_seen++;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_sums.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sum %0d mismatch: expected %p, got %p", sums_seen, want, got);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", quiet);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------- main sequence ----------------
  localparam logic [31:0] P_DEF = 32'd4294967291;
  dir_row_t dir_tab[10];
  logic [31:0] ph_mod[N_PHASES];
  logic [31:0] ph_a[N_PHASES];
  logic [31:0] ph_b[N_PHASES];

  initial begin
    sum_t no_sum;
    no_sum = '{rx: 0, ry: 0, rinf: 0, pon: 0, sing: 0};
    // Default curve y^2 = x^3 + 7 over the default prime.
    dir_tab = '{
      '{'{0, 0, 1, 0, 0, 1}, 1, '{0, 0, 1, 0, 0}},                   // both at infinity
      '{'{0, 0, 1, 5, 6, 0}, 1, '{5, 6, 0, 0, 0}},                   // P at infinity
      '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 9, 9, 1}, 1, '{4, 4, 0, 0, 0}},
      '{'{1, 2, 0, 1, P_DEF - 2, 0}, 1, '{0, 0, 1, 0, 0}},           // Q is -P
      '{'{1, 2, 0, 1, 7, 0}, 1, '{0, 0, 1, 0, 0}},                   // equal x, other y
      '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1, 0, 0}},                   // y zero, self-negating
      '{'{3, 5, 0, 3, 5, 0}, 0, no_sum},                             // doubling
      '{'{1, 2, 0, 3, 4, 0}, 0, no_sum},                             // chord
      '{'{P_DEF + 1, P_DEF + 2, 0, 1, 2, 0}, 0, no_sum},             // unreduced doubling
      '{'{32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0}, 0, no_sum}
    };
    ph_mod = '{32'd97, 32'd0, 32'd15, 32'd3, 32'hFFFF_FFFF, 32'd1009, 32'd65521, P_DEF};
    ph_a   = '{32'd2, 32'd5, 32'd4, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
    ph_b   = '{32'd3, 32'd9, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd7};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_pair(dir_tab[i].pr, dir_tab[i].typed, dir_tab[i].sum);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      logic [31:0] ra, rb;
      ra = ph_a[ph]; rb = ph_b[ph];
      if (ph == 6) begin
        ra = $urandom_range(0, 65520); rb = $urandom_range(0, 65520);
      end
      set_curve(ph_mod[ph], ra, rb);
      idle_on = (ph % 3) != 1;
      if (ph == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_pair(random_pair(), 1'b0, no_sum);
    end
    s_axis_tvalid <= 1'b0;

    wait (expected_sums.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d point pairs sent over %0d curve settings, %0d sums checked",
             pairs_sent, N_PHASES + 1, sums_seen);
    $display("covered: infinity operands, negation, doubling, chord, zero, composite,");
    $display("singular and all-ones moduli, and a long output stall");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
